>>> rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// Atlas tile cache package
// Shared types and sizing constants for the atlas tile cache.
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam int unsigned TILES_PER_SIDE  = 8;
  localparam int unsigned ATLAS_COUNT     = 4;
  localparam int unsigned TILE_TEXELS     = 128;
  localparam int unsigned TILES_PER_ATLAS = TILES_PER_SIDE * TILES_PER_SIDE;
  localparam int unsigned TOTAL_SLOTS     = TILES_PER_ATLAS * ATLAS_COUNT;
  localparam int unsigned TILE_PITCH      = TILE_TEXELS + 2;

  localparam int unsigned SLOT_W  = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int unsigned COUNT_W = $clog2(TOTAL_SLOTS + 1);
  localparam int unsigned SIDE_W  = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
  localparam int unsigned ATL_W   = (TILES_PER_ATLAS > 1) ? $clog2(TILES_PER_ATLAS) : 1;

  localparam logic ACTION_LOOKUP = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic       evicted;
    logic [7:0] slot;
    logic [1:0] atlas_number;
    logic [9:0] origin_x;
    logic [9:0] origin_y;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

>>> rtl/atlas_tile_cache_lru_top.sv
// ----------------------------------------------------------------------------
// Atlas tile cache, top level
// Fully associative tile cache with least recently used replacement.
//
//   Channel   Ports                   Beat taken when
//   request   start, busy, req_i      start high and busy low
//   result    done_o, rsp_o           done_o high, one cycle only
//
// In a lookup the key and stamp memories are read one slot per cycle
// through a registered read port, and a hit ends the search early. A
// clear is done from the idle state, so busy stays low. Reset empties the
// table at once, with no clearing pass. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module atlas_tile_cache_lru_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  atc_pkg::req_t req_i,
  output logic          done_o,
  output atc_pkg::rsp_t rsp_o
);
  import atc_pkg::*;

  cmd_t    cmd;
  status_t status;

  atc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (req_i.action),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  atc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_o),
    .done_o   (done_o)
  );

endmodule

>>> rtl/atc_datapath.sv
// ----------------------------------------------------------------------------
// Atlas tile cache datapath
// Key and stamp memories, the pipelined search for a hit and the oldest
// slot, the fill count, the request counter and the result register.
// ----------------------------------------------------------------------------
module atc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  atc_pkg::req_t    req_i,
  input  atc_pkg::cmd_t    cmd_i,
  output atc_pkg::status_t status_o,
  output atc_pkg::rsp_t    rsp_o,
  output logic             done_o
);
  import atc_pkg::*;

  logic [31:0] keys_mem [TOTAL_SLOTS];
  logic [31:0] stamps_mem [TOTAL_SLOTS];

  logic [COUNT_W-1:0] filled_q, filled_d;
  logic [31:0]        clock_q, clock_d;
  logic [31:0]        key_q, stamp_q;
  logic [COUNT_W-1:0] rd_idx_q, rd_idx_d;
  logic               vld_q;
  logic [SLOT_W-1:0]  cmp_idx_q;
  logic [31:0]        key_rd_q, stamp_rd_q;
  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  hit_idx_q, hit_idx_d;
  logic [SLOT_W-1:0]  best_q, best_d;
  logic [31:0]        best_stamp_q, best_stamp_d;
  logic               first_q, first_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q, done_d;

  logic               issue;
  logic               hit_now;
  logic               full;
  logic [SLOT_W-1:0]  target;
  logic [7:0]         slot_ext;
  logic [SIDE_W-1:0]  col;
  logic [SIDE_W-1:0]  row;
  logic [19:0]        org_x;
  logic [19:0]        org_y;

  assign hit_now = vld_q && !hit_q && (key_rd_q == key_q);
  assign issue   = cmd_i.scan && (rd_idx_q < filled_q) && !hit_q && !hit_now;
  assign full    = ({1'b0, filled_q} + 1'b1) >= (COUNT_W + 1)'(TOTAL_SLOTS);
  assign status_o.scan_done = cmd_i.scan && !vld_q && (hit_q || (rd_idx_q >= filled_q));

  always_comb begin
    if (hit_q) begin
      target = hit_idx_q;
    end else if (full) begin
      target = best_q;
    end else begin
      target = filled_q[SLOT_W-1:0];
    end
  end

  assign slot_ext = 8'(target);
  assign col      = slot_ext[SIDE_W-1:0];
  assign row      = slot_ext[2*SIDE_W-1:SIDE_W];
  assign org_x    = 20'(1 + TILE_PITCH * 20'(col));
  assign org_y    = 20'(1 + TILE_PITCH * 20'(row));

  always_comb begin
    filled_d     = filled_q;
    clock_d      = clock_q;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    first_d      = first_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;
    if (cmd_i.clear) begin
      filled_d = '0;
      rsp_d    = '0;
      done_d   = 1'b1;
    end
    if (cmd_i.load) begin
      clock_d      = clock_q + 32'd1;
      rd_idx_d     = '0;
      hit_d        = 1'b0;
      hit_idx_d    = '0;
      best_d       = '0;
      best_stamp_d = '0;
      first_d      = 1'b1;
    end
    if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
    if (vld_q && !hit_q) begin
      if (hit_now) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (first_q || (stamp_rd_q < best_stamp_q)) begin
        best_d       = cmp_idx_q;
        best_stamp_d = stamp_rd_q;
        first_d      = 1'b0;
      end
    end
    if (cmd_i.write) begin
      if (!hit_q && !full) begin
        filled_d = filled_q + 1'b1;
      end
      rsp_d.hit          = hit_q;
      rsp_d.evicted      = !hit_q && full;
      rsp_d.slot         = slot_ext;
      rsp_d.atlas_number = 2'(slot_ext >> ATL_W);
      rsp_d.origin_x     = org_x[9:0];
      rsp_d.origin_y     = org_y[9:0];
      done_d             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      clock_q  <= '0;
      rd_idx_q <= '0;
      vld_q    <= 1'b0;
      hit_q    <= 1'b0;
      first_q  <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      filled_q <= filled_d;
      clock_q  <= clock_d;
      rd_idx_q <= rd_idx_d;
      vld_q    <= issue;
      hit_q    <= hit_d;
      first_q  <= first_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q    <= hit_idx_d;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    rsp_q        <= rsp_d;
    cmp_idx_q    <= rd_idx_q[SLOT_W-1:0];
    if (cmd_i.load) begin
      key_q   <= req_i.key;
      stamp_q <= clock_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      keys_mem[target]   <= key_q;
      stamps_mem[target] <= stamp_q;
    end
    key_rd_q   <= keys_mem[rd_idx_q[SLOT_W-1:0]];
    stamp_rd_q <= stamps_mem[rd_idx_q[SLOT_W-1:0]];
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

>>> rtl/atc_ctrl.sv
// ----------------------------------------------------------------------------
// Atlas tile cache controller
// Sequences each lookup: capture, search over the filled slots, write-back.
// ----------------------------------------------------------------------------
module atc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             action_i,
  input  atc_pkg::status_t status_i,
  output atc_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import atc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (action_i == ACTION_CLEAR) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> verif/atlas_tile_cache_lru_top_test.sv
// ----------------------------------------------------------------------------
// Atlas tile cache testbench
// Sends lookup and clear requests to the tile cache and checks every result
// against a predictor that keeps its own copy of the slot tags, access stamps,
// fill count and request counter. Directed requests cover key extremes, hits,
// misses and clears. Random requests first use a small key pool, then fill
// the table and go on past full so that least recently used eviction is
// exercised. The sender idles at varying rates and at least once holds off
// until every outstanding result has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atlas_tile_cache_lru_top_test;

  import atc_pkg::*;

  typedef struct {
    req_t req;
    bit   drain_first;
  } tile_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_s  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  tile_item_t  tile_req_q[$];
  rsp_t        expected_rsp_q[$];
  logic [31:0] key_hist[$];

  logic [31:0] tile_tag[TOTAL_SLOTS];
  logic [31:0] tile_stamp[TOTAL_SLOTS];
  int unsigned tiles_used   = 0;
  logic [31:0] lookup_clock = '0;

  logic        req_taken    = 1'b0;
  int unsigned beats_sent   = 0;
  int unsigned total_items  = 0;
  int unsigned mismatches   = 0;

  atlas_tile_cache_lru_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_s),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic rsp_t predict_tile_rsp(input req_t rq);
    rsp_t        r;
    int unsigned idx;
    logic [31:0] stamp;
    bit          found;
    r     = '0;
    idx   = 0;
    found = 1'b0;
    if (rq.action == ACTION_CLEAR) begin
      tiles_used = 0;
    end else begin
      stamp        = lookup_clock;
      lookup_clock = lookup_clock + 32'd1;
      for (int i = 0; i < tiles_used; i++) begin
        if (!found && tile_tag[i] == rq.key) begin
          found = 1'b1;
          idx   = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
      end else if (tiles_used + 1 >= TOTAL_SLOTS) begin
        for (int i = 0; i < tiles_used; i++) begin
          if (tile_stamp[i] < tile_stamp[idx]) idx = i;
        end
        tile_tag[idx] = rq.key;
        r.evicted     = 1'b1;
      end else begin
        idx           = tiles_used;
        tile_tag[idx] = rq.key;
        tiles_used    = tiles_used + 1;
      end
      tile_stamp[idx]  = stamp;
      r.slot           = 8'(idx);
      r.atlas_number   = 2'(idx / TILES_PER_ATLAS);
      r.origin_x       = 10'(1 + TILE_PITCH * (idx % TILES_PER_SIDE));
      r.origin_y       = 10'(1 + TILE_PITCH * ((idx / TILES_PER_SIDE) % TILES_PER_SIDE));
    end
    return r;
  endfunction

  task automatic report_field(input string fname, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_req(input logic act, input logic [31:0] key, input bit drain);
    tile_item_t it;
    it.req.action  = act;
    it.req.key     = key;
    it.drain_first = drain;
    tile_req_q.push_back(it);
  endtask

  always @(negedge clk_i) begin : drive_req
    tile_item_t  nxt;
    int unsigned idle_pct;
    bit          go;
    go = 1'b0;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (beats_sent * 3 < total_items) idle_pct = 26;
      else if (beats_sent * 3 < total_items * 2) idle_pct = 71;
      else idle_pct = 0;
      if (tile_req_q.size() > 0) begin
        nxt = tile_req_q[0];
        if (!(nxt.drain_first && expected_rsp_q.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          go = 1'b1;
          void'(tile_req_q.pop_front());
          req_s <= nxt.req;
          beats_sent++;
        end
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin : watch_rsp
    rsp_t want;
    req_taken <= rst_ni && start && busy === 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, rsp_o);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          report_field("hit", 32'(want.hit), 32'(rsp_o.hit));
          report_field("evicted", 32'(want.evicted), 32'(rsp_o.evicted));
          report_field("slot", 32'(want.slot), 32'(rsp_o.slot));
          report_field("atlas_number", 32'(want.atlas_number), 32'(rsp_o.atlas_number));
          report_field("origin_x", 32'(want.origin_x), 32'(rsp_o.origin_x));
          report_field("origin_y", 32'(want.origin_y), 32'(rsp_o.origin_y));
        end
      end
      if (start && busy === 1'b0) expected_rsp_q.push_back(predict_tile_rsp(req_s));
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("[atlas_tile_cache_lru_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] k;
    int unsigned fresh;

    queue_req(ACTION_CLEAR, 32'h0, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h0000_0000, 1'b0);
    queue_req(ACTION_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h0000_0000, 1'b0);
    queue_req(ACTION_LOOKUP, 32'hAAAA_AAAA, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h5555_5555, 1'b0);
    queue_req(ACTION_LOOKUP, 32'hFFFF_FFFF, 1'b0);
    for (int i = 0; i < 9; i++) queue_req(ACTION_LOOKUP, 32'd100 + i, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h5555_5555, 1'b0);
    queue_req(ACTION_CLEAR, 32'hFFFF_FFFF, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h0000_0000, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h5555_5555, 1'b0);
    queue_req(ACTION_LOOKUP, 32'h0000_0000, 1'b0);
    queue_req(ACTION_CLEAR, 32'h1234_5678, 1'b0);
    queue_req(ACTION_CLEAR, 32'h0, 1'b0);

    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(99) < 8) k = $urandom;
      else if ($urandom_range(99) < 60) k = $urandom_range(15);
      else k = $urandom;
      queue_req(($urandom_range(99) < 8) ? ACTION_CLEAR : ACTION_LOOKUP, k, i == 0);
    end

    queue_req(ACTION_CLEAR, $urandom, 1'b1);
    fresh = 0;
    while (fresh < TOTAL_SLOTS) begin
      if (key_hist.size() > 0 && $urandom_range(99) < 15) begin
        k = key_hist[$urandom_range(key_hist.size() - 1)];
      end else begin
        k = $urandom;
        key_hist.push_back(k);
        fresh++;
      end
      queue_req(ACTION_LOOKUP, k, 1'b0);
    end

    for (int i = 0; i < 90; i++) begin
      if ($urandom_range(99) < 40) begin
        k = $urandom;
        key_hist.push_back(k);
      end else if ($urandom_range(99) < 58) begin
        k = key_hist[key_hist.size() - 1 - $urandom_range(19)];
      end else begin
        k = key_hist[$urandom_range(key_hist.size() - 1)];
      end
      queue_req(ACTION_LOOKUP, k, i == 45);
    end

    queue_req(ACTION_CLEAR, $urandom, 1'b0);
    for (int i = 0; i < 6; i++) begin
      queue_req(ACTION_LOOKUP, key_hist[key_hist.size() - 1 - (i % 3)], 1'b0);
    end

    total_items = tile_req_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (tile_req_q.size() != 0 || start || expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (300) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[atlas_tile_cache_lru_top] OK");
    end else begin
      $display("[atlas_tile_cache_lru_top] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/atc_pkg.sv
rtl/atc_datapath.sv
rtl/atc_ctrl.sv
rtl/atlas_tile_cache_lru_top.sv
verif/atlas_tile_cache_lru_top_test.sv
